### rtl/core/ledtd_pkg.sv
`default_nettype none

package ledtd_pkg;

   localparam int unsigned BRIGHT_W  = 11;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned PHASE_W   = 4;
   localparam int unsigned PATTERN_W = 12;

   localparam logic [BRIGHT_W-1:0] BRIGHT_MAX    = 11'd1530;
   localparam logic [BRIGHT_W-1:0] BRIGHT_MIN    = 11'd50;
   localparam logic [PHASE_W-1:0]  PHASE_LAST    = 4'd11;
   localparam logic [CHAN_W-1:0]   STATUS_FACTOR = 8'd8;
   localparam logic [CHAN_W-1:0]   FULL_FACTOR   = 8'd255;
   localparam logic [15:0]         ROUND_BIAS    = 16'd127;

   // brightness / 6 as (b * 683) >> 12, exact for b up to 1530
   localparam logic [9:0]          RECIP_6       = 10'd683;
   localparam int unsigned         RECIP_SHIFT   = 12;
   localparam logic [BRIGHT_W-1:0] PATTERN_COUNT = 11'd6;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
      logic              status_led;
      logic              frame_end;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_last;
   } rsp_type;

   // decoded brightness, shared by all lanes
   typedef struct packed {
      logic                 zero;
      logic [CHAN_W-1:0]    factor;
      logic [PATTERN_W-1:0] pattern;
   } scale_cfg_type;

   function automatic logic [PATTERN_W-1:0] pattern_of(input logic [2:0] idx);
      logic [PATTERN_W-1:0] pat;
      case (idx)
         3'd0:    pat = 12'h000;
         3'd1:    pat = 12'h820;
         3'd2:    pat = 12'h924;
         3'd3:    pat = 12'hAAA;
         3'd4:    pat = 12'hDB6;
         3'd5:    pat = 12'hFBE;
         default: pat = 12'h000;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

### rtl/core/ledtd_csr.sv
`default_nettype none

module ledtd_csr
   import ledtd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [BRIGHT_W-1:0] csr_data,
   output      scale_cfg_type       cfg
);

   scale_cfg_type cfg_ff, cfg_in;

   logic [BRIGHT_W-1:0] bright;
   logic [20:0]         recip_prod;
   logic [CHAN_W-1:0]   quot;
   logic [BRIGHT_W-1:0] rem_full;

   assign csr_ready = 1'b1;

   always_comb begin
      // clamp into the usable range
      if (csr_data > BRIGHT_MAX) begin
         bright = BRIGHT_MAX;
      end else if (csr_data != '0 && csr_data < BRIGHT_MIN) begin
         bright = BRIGHT_MIN;
      end else begin
         bright = csr_data;
      end
      recip_prod = 21'(bright) * 21'(RECIP_6);
      quot       = recip_prod[RECIP_SHIFT +: CHAN_W];
      rem_full   = bright - (11'(quot) * PATTERN_COUNT);

      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (bright == '0) begin
            cfg_in.zero    = 1'b1;
            cfg_in.factor  = STATUS_FACTOR;
            cfg_in.pattern = pattern_of(3'd0);
         end else begin
            cfg_in.zero    = 1'b0;
            cfg_in.factor  = quot;
            cfg_in.pattern = pattern_of(rem_full[2:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // decode of brightness 1530
         cfg_ff.zero    <= 1'b0;
         cfg_ff.factor  <= FULL_FACTOR;
         cfg_ff.pattern <= pattern_of(3'd0);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   a_zero_decode: assert property (@(posedge clock) disable iff (reset)
      cfg_ff.zero |-> (cfg_ff.factor == STATUS_FACTOR && cfg_ff.pattern == '0))
      else $error("zero brightness decoded with wrong factor or pattern");

endmodule

`default_nettype wire

### rtl/core/ledtd_lane.sv
`default_nettype none

module ledtd_lane
   import ledtd_pkg::*;
(
   input  wire logic [CHAN_W-1:0] chan,
   input  wire logic              status_led,
   input  wire logic              dbit,
   input  wire scale_cfg_type     cfg,
   output      logic [CHAN_W-1:0] chan_scaled
);

   logic [15:0]       prod;
   logic [15:0]       biased;
   logic [CHAN_W-1:0] rounded;
   logic              kill;

   always_comb begin
      prod    = 16'(chan) * 16'(cfg.factor);
      // max is 255*255+127, fits 16 bits
      biased  = prod + ROUND_BIAS;
      rounded = biased[15:8] + CHAN_W'(dbit);
      // zero brightness lights status leds only, otherwise black stays black
      kill    = cfg.zero ? !status_led : (chan == '0);
      chan_scaled = kill ? '0 : rounded;
   end

endmodule

`default_nettype wire

### rtl/core/ledtd_outbuf.sv
`default_nettype none

module ledtd_outbuf
   import ledtd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output      logic    space,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   logic [1:0] count_ff, count_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign space     = (count_ff != 2'd2);
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               slot0_in = push_data;
            end else begin
               slot1_in = push_data;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            slot0_in = slot1_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = push_data;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output buffer overfilled");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push)
      else $error("transfer into a full output buffer");

endmodule

`default_nettype wire

### rtl/core/led_brightness_temporal_dither.sv
// led brightness scaling with temporal dithering
//
// req channel: one led (red, green, blue, status flag, frame end) per transfer.
// rsp channel: one scaled led per transfer, in the same order, frame_last copies
//   frame_end.
// csr channel: writes the 11-bit brightness; csr_ready is always high and the
//   new value applies to every led transferred after the write edge.
// datapath: the three color lanes (one 8x8 multiply each) and the dither select
//   sit combinationally between the req port and a two-entry output buffer,
//   which registers the result at the req transfer.
// throughput: one led per cycle while the output buffer has space; the lanes are combinational.
// stall: while rsp_ready is low the buffer still takes leds into free entries; req_ready
//   falls only when both entries are full.
// reset: brightness 1530, dither phase 0, output buffer empty.
// dither phase counts 0..11 and steps after every led marked frame_end,
//   at every brightness including zero.

`default_nettype none

module led_brightness_temporal_dither
   import ledtd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire req_type             req_data,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      rsp_type             rsp_data,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [BRIGHT_W-1:0] csr_data
);

   scale_cfg_type      cfg;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               accept;
   logic               dbit;
   rsp_type            result;

   // decoded brightness: zero flag, factor and dither pattern
   ledtd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign accept = req_valid && req_ready;

   // dither bit for this frame
   assign dbit = cfg.pattern[phase_ff];

   // one lane per color
   ledtd_lane u_lane_red (
      .chan        (req_data.red_in),
      .status_led  (req_data.status_led),
      .dbit        (dbit),
      .cfg         (cfg),
      .chan_scaled (result.red_out)
   );

   ledtd_lane u_lane_green (
      .chan        (req_data.green_in),
      .status_led  (req_data.status_led),
      .dbit        (dbit),
      .cfg         (cfg),
      .chan_scaled (result.green_out)
   );

   ledtd_lane u_lane_blue (
      .chan        (req_data.blue_in),
      .status_led  (req_data.status_led),
      .dbit        (dbit),
      .cfg         (cfg),
      .chan_scaled (result.blue_out)
   );

   assign result.frame_last = req_data.frame_end;

   // merge the lanes into the output buffer
   ledtd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .space     (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // frame phase, wraps after the twelfth frame
   always_comb begin
      phase_in = phase_ff;
      if (accept && req_data.frame_end) begin
         phase_in = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_LAST)
      else $error("dither phase out of range");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !(accept && req_data.frame_end) |=> $stable(phase_ff))
      else $error("dither phase moved without a frame end");

   a_phase_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.frame_end && phase_ff == PHASE_LAST) |=> phase_ff == '0)
      else $error("dither phase did not wrap");

endmodule

`default_nettype wire

### tb/testbench.sv
module testbench;
   import ledtd_pkg::*;

   // one row of the directed table: an optional brightness write ahead of the led,
   // and, where it is obvious, the scaled led typed in by hand
   typedef struct packed {
      logic                csr_write;
      logic [BRIGHT_W-1:0] level;
      req_type             led;
      logic                pinned;
      rsp_type             want;
   } led_row_type;

   typedef struct packed {
      logic    pinned;
      rsp_type want;
   } pin_type;

   // dither patterns indexed by brightness mod 6
   localparam logic [5:0][PATTERN_W-1:0] DITHER_SET =
      {12'hFBE, 12'hDB6, 12'hAAA, 12'h924, 12'h820, 12'h000};

   localparam int unsigned LEDS_PER_LEVEL = 102;
   localparam int unsigned LEVELS_PER_MODE = 5;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [BRIGHT_W-1:0] csr_data = '0;

   // predictor state, follows the block through every csr and req transfer
   logic [BRIGHT_W-1:0] brightness_copy = BRIGHT_MAX;
   logic [PHASE_W-1:0]  frame_phase = '0;

   rsp_type     scaled_led_q[$];
   pin_type     pinned_q[$];
   led_row_type led_rows[$];

   int unsigned leds_sent = 0;
   int unsigned results_seen = 0;
   int unsigned error_count = 0;
   int unsigned sender_idle_pct = 31;
   int unsigned receiver_idle_pct = 68;

   led_brightness_temporal_dither dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // one channel: rounded product, shifted down, plus the dither bit
   function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                    input int unsigned factor,
                                                    input logic dbit);
      int unsigned prod;
      prod = ((c * factor + ROUND_BIAS) >> 8) + dbit;
      return prod[CHAN_W-1:0];
   endfunction

   function automatic rsp_type scale_led(input req_type led,
                                         input logic [BRIGHT_W-1:0] level,
                                         input logic [PHASE_W-1:0] phase);
      int unsigned eff;
      int unsigned factor;
      logic        dbit;
      rsp_type     res;
      eff = level;
      // clamp above range, lift the low end to the minimum
      if (eff > BRIGHT_MAX) eff = BRIGHT_MAX;
      if (eff != 0 && eff < BRIGHT_MIN) eff = BRIGHT_MIN;
      dbit = DITHER_SET[eff % 6][phase];
      res = '0;
      res.frame_last = led.frame_end;
      if (eff == 0) begin
         // dark mode: only status leds glow, zero channels go through the scaler too
         if (led.status_led) begin
            res.red_out   = scale_chan(led.red_in, STATUS_FACTOR, dbit);
            res.green_out = scale_chan(led.green_in, STATUS_FACTOR, dbit);
            res.blue_out  = scale_chan(led.blue_in, STATUS_FACTOR, dbit);
         end
      end else begin
         factor = eff / 6;
         // a dark channel stays dark, no dither added
         if (led.red_in != 0)   res.red_out   = scale_chan(led.red_in, factor, dbit);
         if (led.green_in != 0) res.green_out = scale_chan(led.green_in, factor, dbit);
         if (led.blue_in != 0)  res.blue_out  = scale_chan(led.blue_in, factor, dbit);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // sampled at the edge, before any of this edge's updates land
   always @(posedge clock) begin
      pin_type pin;
      rsp_type predicted;
      rsp_type want;
      if (reset) begin
         brightness_copy = BRIGHT_MAX;
         frame_phase     = '0;
      end else begin
         if (csr_valid && csr_ready) brightness_copy = csr_data;
         if (req_valid && req_ready) begin
            pin       = pinned_q.pop_front();
            predicted = scale_led(req_data, brightness_copy, frame_phase);
            scaled_led_q.push_back(pin.pinned ? pin.want : predicted);
            // phase steps after the last led of a frame, at any brightness
            if (req_data.frame_end)
               frame_phase = (frame_phase == PHASE_LAST) ? '0 : frame_phase + 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (scaled_led_q.size() == 0) begin
               $error("unexpected rsp transfer: %h", rsp_data);
               error_count++;
            end else begin
               want = scaled_led_q.pop_front();
               check_field("red_out", want.red_out, rsp_data.red_out);
               check_field("green_out", want.green_out, rsp_data.green_out);
               check_field("blue_out", want.blue_out, rsp_data.blue_out);
               check_field("frame_last", want.frame_last, rsp_data.frame_last);
               results_seen++;
            end
         end
      end
   end

   // receiver stalls at random, rate set per run phase
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   // valid stays up between back-to-back leds, only dropped for an idle gap
   task automatic send_led(input req_type led, input logic pinned, input rsp_type want);
      pin_type pin;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pin.pinned = pinned;
      pin.want   = want;
      pinned_q.push_back(pin);
      req_valid <= 1'b1;
      req_data  <= led;
      do @(posedge clock); while (!req_ready);
      leds_sent++;
   endtask

   // wait until every led sent has come back, so the block is idle
   task automatic drain();
      req_valid <= 1'b0;
      wait (results_seen == leds_sent);
      @(posedge clock);
   endtask

   task automatic write_brightness(input logic [BRIGHT_W-1:0] level);
      csr_valid <= 1'b1;
      csr_data  <= level;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic led_row_type make_row(input logic csr_write, input int unsigned level,
                                            input int unsigned r, input int unsigned g,
                                            input int unsigned b, input logic status,
                                            input logic last, input logic pinned,
                                            input int unsigned ro, input int unsigned go,
                                            input int unsigned bo);
      led_row_type row;
      row.csr_write       = csr_write;
      row.level           = BRIGHT_W'(level);
      row.led.red_in      = CHAN_W'(r);
      row.led.green_in    = CHAN_W'(g);
      row.led.blue_in     = CHAN_W'(b);
      row.led.status_led  = status;
      row.led.frame_end   = last;
      row.pinned          = pinned;
      row.want.red_out    = CHAN_W'(ro);
      row.want.green_out  = CHAN_W'(go);
      row.want.blue_out   = CHAN_W'(bo);
      row.want.frame_last = last;
      return row;
   endfunction

   initial begin
      req_type     led;
      int unsigned mode;
      int unsigned seg;
      int unsigned k;
      int unsigned pick;
      logic [BRIGHT_W-1:0] level;
      logic [CHAN_W-1:0]   chan [3];

      // directed rows
      // reset brightness 1530 uses the flat pattern, so no dither: c*255 rounded
      led_rows.push_back(make_row(0, 0, 255, 255, 255, 0, 0, 1, 254, 254, 254));
      led_rows.push_back(make_row(0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0));
      led_rows.push_back(make_row(0, 0, 1, 128, 255, 0, 1, 1, 1, 127, 254));
      // zero brightness: plain led goes black, status led uses the small factor
      led_rows.push_back(make_row(1, 0, 200, 100, 50, 0, 0, 1, 0, 0, 0));
      led_rows.push_back(make_row(0, 0, 255, 0, 128, 1, 0, 1, 8, 0, 4));
      led_rows.push_back(make_row(0, 0, 255, 255, 255, 1, 1, 1, 8, 8, 8));
      // above range acts as full brightness
      led_rows.push_back(make_row(1, 2047, 255, 0, 1, 0, 0, 1, 254, 0, 1));
      led_rows.push_back(make_row(1, 1531, 255, 255, 255, 0, 1, 1, 254, 254, 254));
      // low end lifted to the minimum, and the minimum itself
      led_rows.push_back(make_row(1, 1, 255, 255, 255, 0, 0, 0, 0, 0, 0));
      led_rows.push_back(make_row(1, 49, 1, 2, 3, 1, 1, 0, 0, 0, 0));
      led_rows.push_back(make_row(1, 50, 255, 128, 1, 0, 0, 0, 0, 0, 0));
      // each dither pattern near the top, phase stepping every row
      led_rows.push_back(make_row(1, 1529, 255, 255, 255, 0, 1, 0, 0, 0, 0));
      led_rows.push_back(make_row(0, 0, 1, 1, 1, 0, 1, 0, 0, 0, 0));
      led_rows.push_back(make_row(1, 1525, 128, 64, 32, 1, 1, 0, 0, 0, 0));
      led_rows.push_back(make_row(1, 1526, 17, 34, 51, 0, 1, 0, 0, 0, 0));
      led_rows.push_back(make_row(1, 1527, 240, 15, 1, 1, 1, 0, 0, 0, 0));
      led_rows.push_back(make_row(1, 1528, 255, 0, 255, 0, 1, 0, 0, 0, 0));
      // back to full and zero, phase wraps from eleven to zero here
      led_rows.push_back(make_row(1, 1530, 255, 255, 255, 1, 1, 1, 254, 254, 254));
      led_rows.push_back(make_row(0, 0, 0, 0, 255, 0, 1, 1, 0, 0, 254));
      led_rows.push_back(make_row(1, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (led_rows[i]) begin
         if (led_rows[i].csr_write) begin
            drain();
            write_brightness(led_rows[i].level);
         end
         send_led(led_rows[i].led, led_rows[i].pinned, led_rows[i].want);
      end

      // random part: receiver-heavy idling, then sender-heavy, then none
      for (mode = 0; mode < 3; mode++) begin
         drain();
         sender_idle_pct   = (mode == 0) ? 31 : (mode == 1) ? 68 : 0;
         receiver_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 31 : 0;
         for (seg = 0; seg < LEVELS_PER_MODE; seg++) begin
            drain();
            // brightness mix leans on the extremes and the lifted low end
            pick = $urandom_range(0, 7);
            if (pick == 0)      level = '0;
            else if (pick == 1) level = BRIGHT_MAX;
            else if (pick == 2) level = '1;
            else if (pick == 3) level = BRIGHT_W'($urandom_range(1, BRIGHT_MIN - 1));
            else                level = BRIGHT_W'($urandom_range(0, 2047));
            write_brightness(level);
            for (k = 0; k < LEDS_PER_LEVEL; k++) begin
               foreach (chan[c]) begin
                  pick = $urandom_range(0, 7);
                  chan[c] = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
                            CHAN_W'($urandom_range(0, 255));
               end
               led.red_in     = chan[0];
               led.green_in   = chan[1];
               led.blue_in    = chan[2];
               led.status_led = 1'($urandom_range(0, 1));
               // short frames so the phase runs around many times
               led.frame_end  = ($urandom_range(0, 5) == 0);
               send_led(led, 1'b0, '0);
            end
         end
      end

      drain();
      // keep the clock running to catch any stray rsp transfer
      repeat (8) @(posedge clock);
      if (error_count == 0 && scaled_led_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

endmodule
